>>> rtl/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types, constants and commutation tables of the hall commutation
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

    // widths
    localparam int TIME_W    = 32;
    localparam int HALL_W    = 3;
    localparam int LEVEL_W   = 8;
    localparam int DUTY_W    = 16;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int PROD_W    = LEVEL_W + DUTY_W;

    // packet type field of a received byte
    localparam logic [7:0] PKT_TYPE_MASK = 8'hC0;
    localparam logic [7:0] PKT_THROTTLE  = 8'h00;

    // phase enable with every channel on
    localparam logic [2:0] EN_ALL = 3'b111;

    // sector used for invalid hall codes
    localparam logic [2:0] SECTOR_IDLE = 3'd6;

    // register reset values
    localparam logic                 RST_DIR      = 1'b0;
    localparam logic [DUTY_W-1:0]    RST_PWM      = 16'd1023;
    localparam logic [LEVEL_W-1:0]   RST_BRAKE    = 8'd20;
    localparam logic [PERIOD_W-1:0]  RST_TIMEOUT  = 16'd16000;
    localparam logic [7:0]           RST_DEBOUNCE = 8'd10;
    localparam logic [TIME_W-1:0]    RST_REPORT   = 32'd100000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 3'd0,
        CFG_PWM       = 3'd1,
        CFG_BRAKE     = 3'd2,
        CFG_TIMEOUT   = 3'd3,
        CFG_DEBOUNCE  = 3'd4,
        CFG_REPORT    = 3'd5
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic                direction_select;
        logic [DUTY_W-1:0]   pwm_limit;
        logic [LEVEL_W-1:0]  brake_threshold;
        logic [PERIOD_W-1:0] speed_timeout_us;
        logic [7:0]          debounce_passes;
        logic [TIME_W-1:0]   report_interval_us;
    } t_cfg;

    // one control pass request
    typedef struct packed {
        logic [HALL_W-1:0] hall_bits;
        logic [TIME_W-1:0] now_us;
        logic              byte_valid;
        logic [7:0]        rx_byte;
    } t_in_item;

    // one pass result
    typedef struct packed {
        logic [2:0]          phase_enable;
        logic [DUTY_W-1:0]   duty_a;
        logic [DUTY_W-1:0]   duty_b;
        logic [DUTY_W-1:0]   duty_c;
        logic                braking;
        logic [PERIOD_W-1:0] speed_period_us;
        logic                report_strobe;
    } t_out_item;

    // classified pass handed from front to back
    typedef struct packed {
        logic [2:0]          sector;
        logic [LEVEL_W-1:0]  throttle;
        logic [PERIOD_W-1:0] period;
        logic                strobe;
    } t_cmd;

    // raw hall code to sector
    function automatic logic [2:0] sector_of_hall(input logic [HALL_W-1:0] hall);
        logic [2:0] s;
        unique case (hall)
            3'd0:    s = 3'd6;
            3'd1:    s = 3'd4;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd3;
            3'd4:    s = 3'd0;
            3'd5:    s = 3'd5;
            3'd6:    s = 3'd1;
            default: s = SECTOR_IDLE;
        endcase
        return s;
    endfunction

    // sector to channel enables
    function automatic logic [2:0] enable_of_sector(input logic [2:0] sector);
        logic [2:0] e;
        unique case (sector)
            3'd0:    e = 3'd5;
            3'd1:    e = 3'd3;
            3'd2:    e = 3'd6;
            3'd3:    e = 3'd5;
            3'd4:    e = 3'd3;
            3'd5:    e = 3'd6;
            default: e = 3'd0;
        endcase
        return e;
    endfunction

    // sector to driven phases, forward
    function automatic logic [2:0] drive_fwd(input logic [2:0] sector);
        logic [2:0] d;
        unique case (sector)
            3'd0:    d = 3'd4;
            3'd1:    d = 3'd2;
            3'd2:    d = 3'd2;
            3'd3:    d = 3'd1;
            3'd4:    d = 3'd1;
            3'd5:    d = 3'd4;
            default: d = 3'd0;
        endcase
        return d;
    endfunction

    // sector to driven phases, reverse
    function automatic logic [2:0] drive_rev(input logic [2:0] sector);
        logic [2:0] d;
        unique case (sector)
            3'd0:    d = 3'd1;
            3'd1:    d = 3'd1;
            3'd2:    d = 3'd4;
            3'd3:    d = 3'd4;
            3'd4:    d = 3'd2;
            3'd5:    d = 3'd2;
            default: d = 3'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bhc_front.sv
// ----------------------------------------------------------------------------
// bhc_front
// Accepts control passes: hall debounce, period measurement, pedal byte
// decode and the periodic stale-speed check. Emits one classified pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_front import bhc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_take,
    input  wire t_in_item i_item,
    output t_cmd          o_cmd
);

    logic [HALL_W-1:0]   r_hall, n_hall;
    logic [7:0]          r_count, n_count;
    logic [TIME_W-1:0]   r_last_change, n_last_change;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [LEVEL_W-1:0]  r_throttle, n_throttle;
    logic [TIME_W-1:0]   r_last_report, n_last_report;

    logic [TIME_W-1:0]   w_dt_change;
    logic [TIME_W-1:0]   w_dt_report;
    logic [7:0]          w_count_inc;
    logic                w_accept_hall;
    logic                w_report;
    logic                w_stale;

    // elapsed times, modulo the timer width
    assign w_dt_change = i_item.now_us - r_last_change;
    assign w_dt_report = i_item.now_us - r_last_report;
    assign w_count_inc = r_count + 8'd1;

    assign w_accept_hall = (i_item.hall_bits != r_hall) && (w_count_inc == i_cfg.debounce_passes);
    assign w_report      = w_dt_report > i_cfg.report_interval_us;
    // a change accepted in this pass restarts the period, so it is never stale
    assign w_stale       = !w_accept_hall
                         && (w_dt_change > {{(TIME_W-PERIOD_W){1'b0}}, i_cfg.speed_timeout_us});

    // next state of one pass
    always_comb begin
        n_hall        = r_hall;
        n_count       = r_count;
        n_last_change = r_last_change;
        n_period      = r_period;
        n_throttle    = r_throttle;
        n_last_report = r_last_report;

        // debounce and period measurement
        if (i_item.hall_bits != r_hall) begin
            n_count = w_count_inc;
            if (w_accept_hall) begin
                n_count       = 8'd0;
                n_last_change = i_item.now_us;
                n_hall        = i_item.hall_bits;
                if (w_dt_change > {{(TIME_W-PERIOD_W){1'b0}}, i_cfg.speed_timeout_us}) begin
                    n_period = '0;
                end else begin
                    n_period = w_dt_change[PERIOD_W-1:0];
                end
            end
        end else begin
            n_count = 8'd0;
        end

        // pedal byte
        if (i_item.byte_valid && ((i_item.rx_byte & PKT_TYPE_MASK) == PKT_THROTTLE)) begin
            n_throttle = {i_item.rx_byte[5:0], 2'b00};
        end

        // periodic stale-speed check
        if (w_report) begin
            n_last_report = i_item.now_us;
            if (w_stale) begin
                n_period = '0;
            end
        end
    end

    // classified pass: sector from this pass's raw hall code, throttle and period from the state after this pass
    always_comb begin
        o_cmd.sector   = sector_of_hall(i_item.hall_bits);
        o_cmd.throttle = n_throttle;
        o_cmd.period   = n_period;
        o_cmd.strobe   = w_report;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hall        <= '0;
            r_count       <= '0;
            r_last_change <= '0;
            r_period      <= '0;
            r_throttle    <= '0;
            r_last_report <= '0;
        end else if (i_take) begin
            r_hall        <= n_hall;
            r_count       <= n_count;
            r_last_change <= n_last_change;
            r_period      <= n_period;
            r_throttle    <= n_throttle;
            r_last_report <= n_last_report;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bhc_queue.sv
// ----------------------------------------------------------------------------
// bhc_queue
// Two-entry queue of classified passes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_queue import bhc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_cmd   = r_mem[r_rptr];

    // pointer and fill update
    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = i_pop  ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bhc_back.sv
// ----------------------------------------------------------------------------
// bhc_back
// Carries out a classified pass: brake decision, phase tables and duty
// scaling into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_back import bhc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_empty,
    input  wire t_cmd  i_cmd,
    output logic       o_pop,
    input  wire logic  i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    logic        r_valid;
    t_out_item   r_data, n_data;
    logic [PROD_W-1:0] w_prod;
    logic [DUTY_W-1:0] w_duty;
    logic [2:0]  w_drv;
    logic        w_brake;

    // take the next pass when the output register is free or leaving
    assign o_pop = !i_q_empty && (!r_valid || !i_out_stall);

    // duty scaling: level * pwm limit / 256
    assign w_prod  = {{DUTY_W{1'b0}}, i_cmd.throttle} * {{LEVEL_W{1'b0}}, i_cfg.pwm_limit};
    assign w_duty  = w_prod[PROD_W-1:LEVEL_W];
    assign w_brake = (i_cmd.throttle < i_cfg.brake_threshold) && (i_cmd.period == '0);
    assign w_drv   = i_cfg.direction_select ? drive_fwd(i_cmd.sector)
                                            : drive_rev(i_cmd.sector);

    // result assembly
    always_comb begin
        n_data.duty_a          = '0;
        n_data.duty_b          = '0;
        n_data.duty_c          = '0;
        n_data.braking         = w_brake;
        n_data.speed_period_us = i_cmd.period;
        n_data.report_strobe   = i_cmd.strobe;
        if (w_brake) begin
            n_data.phase_enable = EN_ALL;
        end else begin
            n_data.phase_enable = enable_of_sector(i_cmd.sector);
            if (w_drv[2]) n_data.duty_a = w_duty;
            if (w_drv[1]) n_data.duty_b = w_duty;
            if (w_drv[0]) n_data.duty_c = w_duty;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/bldc_hall_commutation_controller.sv
// ----------------------------------------------------------------------------
// bldc_hall_commutation_controller
// Six-step hall commutation controller: one request per control pass,
// one result per request.
// ----------------------------------------------------------------------------
// path: a request is queued, then popped into the back stage's output register
// throughput: one request per cycle unless the queue is full; a single duty
//   multiplier and output register retire one pass per cycle unless stalled
// reset: synchronous, active low; clears the motor state and queue and loads
//   the register defaults
`default_nettype none

module bldc_hall_commutation_controller import bhc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data
);

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_take;
    logic w_q_full;
    logic w_q_empty;
    logic w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction_select   <= RST_DIR;
            r_cfg.pwm_limit          <= RST_PWM;
            r_cfg.brake_threshold    <= RST_BRAKE;
            r_cfg.speed_timeout_us   <= RST_TIMEOUT;
            r_cfg.debounce_passes    <= RST_DEBOUNCE;
            r_cfg.report_interval_us <= RST_REPORT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIRECTION: r_cfg.direction_select   <= i_cfg_wdata[0];
                CFG_PWM:       r_cfg.pwm_limit          <= i_cfg_wdata[DUTY_W-1:0];
                CFG_BRAKE:     r_cfg.brake_threshold    <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_TIMEOUT:   r_cfg.speed_timeout_us   <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_DEBOUNCE:  r_cfg.debounce_passes    <= i_cfg_wdata[7:0];
                CFG_REPORT:    r_cfg.report_interval_us <= i_cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // request handshake
    assign o_in_stall = w_q_full;
    assign w_take     = i_in_valid && !w_q_full;

    bhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (w_take),
        .i_item  (i_in_data),
        .o_cmd   (w_front_cmd)
    );

    bhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    bhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // brake drives all channels at zero duty
    a_brake_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.braking) |->
            (o_out_data.phase_enable == EN_ALL) && (o_out_data.duty_a == '0)
            && (o_out_data.duty_b == '0) && (o_out_data.duty_c == '0))
        else $error("brake result with drive applied");

    // brake only at standstill
    a_brake_standstill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.braking) |-> (o_out_data.speed_period_us == '0))
        else $error("brake result with nonzero speed");

    // a full queue always has an entry to hand to the back stage
    a_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> (!w_q_empty && (w_pop == !(o_out_valid && i_out_stall))))
        else $error("queue full without a pending pass");

    // a pass taken by the back stage shows up as a valid result
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("popped pass produced no result");

endmodule

`default_nettype wire

>>> dv/bhc_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// bhc_scoreboard_pkg
// Pass predictor and result scoreboard for the hall commutation controller:
// keeps its own copy of the registers and motor state and queues the drive
// expected for every request taken.
// ----------------------------------------------------------------------------
package bhc_scoreboard_pkg;

    import bhc_pkg::*;

    // hall code to sector, hall 7 in the top slot
    localparam logic [23:0] HALL_SECTOR_LUT = {3'd6, 3'd1, 3'd5, 3'd0, 3'd3, 3'd2, 3'd4, 3'd6};
    // sector to channel enables, sector 6 in the top slot
    localparam logic [20:0] SECTOR_ENABLE_LUT = {3'd0, 3'd6, 3'd3, 3'd5, 3'd6, 3'd3, 3'd5};
    // sector to driven phases per direction
    localparam logic [20:0] DRIVE_FWD_LUT = {3'd0, 3'd4, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4};
    localparam logic [20:0] DRIVE_REV_LUT = {3'd0, 3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd1};

    class commutation_scoreboard;

        // register copy
        bit                  dir_fwd;
        bit [DUTY_W-1:0]     pwm_top;
        bit [LEVEL_W-1:0]    brake_level;
        bit [PERIOD_W-1:0]   stale_limit;
        bit [7:0]            debounce_len;
        bit [TIME_W-1:0]     report_gap;

        // motor state copy
        bit [HALL_W-1:0]     stable_hall;
        bit [7:0]            glitch_run;
        bit [TIME_W-1:0]     last_edge_us;
        bit [PERIOD_W-1:0]   edge_period;
        bit [LEVEL_W-1:0]    throttle;
        bit [TIME_W-1:0]     last_report_us;

        t_out_item           drive_q[$];
        int                  mismatches;

        function new();
            dir_fwd        = RST_DIR;
            pwm_top        = RST_PWM;
            brake_level    = RST_BRAKE;
            stale_limit    = RST_TIMEOUT;
            debounce_len   = RST_DEBOUNCE;
            report_gap     = RST_REPORT;
            stable_hall    = '0;
            glitch_run     = '0;
            last_edge_us   = '0;
            edge_period    = '0;
            throttle       = '0;
            last_report_us = '0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_DIRECTION: dir_fwd      = val[0];
                CFG_PWM:       pwm_top      = val[DUTY_W-1:0];
                CFG_BRAKE:     brake_level  = val[LEVEL_W-1:0];
                CFG_TIMEOUT:   stale_limit  = val[PERIOD_W-1:0];
                CFG_DEBOUNCE:  debounce_len = val[7:0];
                CFG_REPORT:    report_gap   = val;
                default: ;
            endcase
        endfunction

        function bit [DUTY_W-1:0] compare_value();
            bit [PROD_W-1:0] prod;
            prod = throttle * pwm_top;
            return prod[PROD_W-1:LEVEL_W];
        endfunction

        // one control pass: debounce, pedal byte, report check, drive
        function t_out_item commutate(t_in_item req);
            t_out_item       drv;
            bit [TIME_W-1:0] dt;
            bit [2:0]        sector;
            bit [2:0]        driven;
            bit [DUTY_W-1:0] duty;

            drv = '0;

            // hall debounce and period measurement
            if (req.hall_bits != stable_hall) begin
                glitch_run = glitch_run + 8'd1;
                if (glitch_run == debounce_len) begin
                    dt           = req.now_us - last_edge_us;
                    glitch_run   = '0;
                    last_edge_us = req.now_us;
                    edge_period  = (dt > {16'd0, stale_limit}) ? '0 : dt[PERIOD_W-1:0];
                    stable_hall  = req.hall_bits;
                end
            end else begin
                glitch_run = '0;
            end

            // pedal byte
            if (req.byte_valid && ((req.rx_byte & PKT_TYPE_MASK) == PKT_THROTTLE))
                throttle = {req.rx_byte[5:0], 2'b00};

            // periodic stale-speed check
            if ((req.now_us - last_report_us) > report_gap) begin
                last_report_us = req.now_us;
                if ((req.now_us - last_edge_us) > {16'd0, stale_limit})
                    edge_period = '0;
                drv.report_strobe = 1'b1;
            end

            drv.speed_period_us = edge_period;
            drv.braking         = (throttle < brake_level) && (edge_period == '0);

            // hard brake or table drive
            if (drv.braking) begin
                drv.phase_enable = EN_ALL;
            end else begin
                sector           = HALL_SECTOR_LUT[3*req.hall_bits +: 3];
                drv.phase_enable = SECTOR_ENABLE_LUT[3*sector +: 3];
                driven = dir_fwd ? DRIVE_FWD_LUT[3*sector +: 3] : DRIVE_REV_LUT[3*sector +: 3];
                duty   = compare_value();
                if (driven[2]) drv.duty_a = duty;
                if (driven[1]) drv.duty_b = duty;
                if (driven[0]) drv.duty_c = duty;
            end
            return drv;
        endfunction

        function void note_request(t_in_item req);
            drive_q.push_back(commutate(req));
        endfunction

        function int outstanding();
            return drive_q.size();
        endfunction

        function void log_mismatch(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch (%s): expected en=%0d a=%0d b=%0d c=%0d brk=%0b per=%0d ",
                          "rpt=%0b, got en=%0d a=%0d b=%0d c=%0d brk=%0b per=%0d rpt=%0b"},
                         what,
                         want.phase_enable, want.duty_a, want.duty_b, want.duty_c,
                         want.braking, want.speed_period_us, want.report_strobe,
                         got.phase_enable, got.duty_a, got.duty_b, got.duty_c,
                         got.braking, got.speed_period_us, got.report_strobe);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            string     bad;

            if (drive_q.size() == 0) begin
                log_mismatch("no request outstanding", '0, got);
                return;
            end
            want = drive_q.pop_front();
            bad  = "";
            if (got.phase_enable    !== want.phase_enable)    bad = {bad, " phase_enable"};
            if (got.duty_a          !== want.duty_a)          bad = {bad, " duty_a"};
            if (got.duty_b          !== want.duty_b)          bad = {bad, " duty_b"};
            if (got.duty_c          !== want.duty_c)          bad = {bad, " duty_c"};
            if (got.braking         !== want.braking)         bad = {bad, " braking"};
            if (got.speed_period_us !== want.speed_period_us) bad = {bad, " speed_period_us"};
            if (got.report_strobe   !== want.report_strobe)   bad = {bad, " report_strobe"};
            if (bad != "")
                log_mismatch({"field", bad}, want, got);
        endfunction

    endclass

endpackage

>>> dv/tb_bldc_hall_commutation_controller.sv
// ----------------------------------------------------------------------------
// tb_bldc_hall_commutation_controller
// Drives control passes into the commutation controller with random gaps and
// result back-pressure, walks the register set through several settings and
// checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_bldc_hall_commutation_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import bhc_pkg::*;
    import bhc_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

    // valid hall codes in forward rotation order, first code in the low slot
    localparam logic [17:0] SPIN_SEQ = {3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;

    commutation_scoreboard sb = new();

    bit          send_idle_on;
    bit          recv_idle_on;
    int          cycle_count;

    // motor emulation for the random passes
    bit [31:0]   now_gen;
    int          seq_pos;
    int          hold_left;
    bit          spin_fwd;
    int          step_max;
    int          deb_eff;

    bldc_hall_commutation_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, 13)) : 0;
    endfunction

    // result back-pressure
    initial begin
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            n = draw_wait(recv_idle_on);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    function automatic t_in_item mk_pass(logic [2:0] hall, logic [31:0] now,
                                         logic bv, logic [7:0] rx);
        t_in_item it;
        it.hall_bits  = hall;
        it.now_us     = now;
        it.byte_valid = bv;
        it.rx_byte    = rx;
        return it;
    endfunction

    // one request, entered and left at a falling edge
    task automatic send_request(input t_in_item req, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off requests until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_registers(input bit dir, input int pwm, input int brk,
                                  input int tmo, input int deb, input bit [31:0] rpt);
        write_reg(CFG_DIRECTION, {31'd0, dir});
        write_reg(CFG_PWM,       32'(pwm));
        write_reg(CFG_BRAKE,     32'(brk));
        write_reg(CFG_TIMEOUT,   32'(tmo));
        write_reg(CFG_DEBOUNCE,  32'(deb));
        write_reg(CFG_REPORT,    rpt);
        deb_eff  = (deb == 0) ? 256 : deb;
        step_max = (2 * (tmo + 500)) / (deb_eff + 3) + 1;
    endtask

    // next pass: mostly a turning motor, some glitches and time jumps
    function automatic t_in_item next_pass();
        t_in_item it;
        int       roll;
        it   = '0;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            now_gen = now_gen + $urandom_range(0, step_max);
            if (hold_left <= 0) begin
                seq_pos   = spin_fwd ? (seq_pos + 1) % 6 : (seq_pos + 5) % 6;
                hold_left = deb_eff + $urandom_range(0, 4);
                // motor sits still for a while
                if ($urandom_range(0, 19) == 0)
                    hold_left += $urandom_range(20, 80);
            end
            hold_left--;
            it.hall_bits = SPIN_SEQ[3*seq_pos +: 3];
        end else begin
            it.hall_bits = 3'($urandom_range(0, 7));
            if (roll < 88)
                now_gen = $urandom();
            else if (roll < 92)
                now_gen = now_gen + $urandom_range(0, 200000);
            else
                now_gen = now_gen + $urandom_range(0, step_max);
        end
        it.now_us = now_gen;
        if ($urandom_range(0, 4) == 0) begin
            it.byte_valid = 1'b1;
            if ($urandom_range(0, 9) < 7)
                it.rx_byte = {2'b00, 6'($urandom())};
            else
                it.rx_byte = 8'($urandom());
        end else begin
            it.rx_byte = 8'($urandom());
        end
        return it;
    endfunction

    task automatic run_phase(input bit dir, input int pwm, input int brk, input int tmo,
                             input int deb, input bit [31:0] rpt, input int n_items);
        int k;
        drain_results();
        load_registers(dir, pwm, brk, tmo, deb, rpt);
        // time base: carry on, jump anywhere, or sit just below the wrap
        case ($urandom_range(0, 2))
            0: now_gen = $urandom();
            1: now_gen = 32'hFFFF_FFFF - $urandom_range(0, 50000);
            default: ;
        endcase
        spin_fwd = $urandom_range(0, 1);
        for (k = 0; k < n_items; k++) begin
            if (k % 50 == 0) begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_request(next_pass(), draw_wait(send_idle_on));
        end
    endtask

    // stimulus
    initial begin
        int p;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        cycle_count  = 0;
        now_gen      = '0;
        seq_pos      = 0;
        hold_left    = 0;
        spin_fwd     = 1'b1;
        deb_eff      = 10;
        step_max     = 100;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: standstill brake, invalid halls, ignored byte kinds
        send_request(mk_pass(3'd0, 32'd0,      1'b0, 8'h00), 0);
        send_request(mk_pass(3'd7, 32'd5,      1'b1, 8'hC5), 0);
        send_request(mk_pass(3'd4, 32'd10,     1'b1, 8'h3F), 0);
        send_request(mk_pass(3'd7, 32'd20,     1'b0, 8'h05), 1);
        send_request(mk_pass(3'd1, 32'd30,     1'b1, 8'h7F), 0);
        send_request(mk_pass(3'd2, 32'd200000, 1'b1, 8'hBF), 2);
        drain_results();

        // extremes: single-pass debounce, report on any time step, spare indexes
        load_registers(1'b1, 65535, 255, 65535, 1, 32'd0);
        write_reg(CFG_UNUSED_A, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_B, 32'h0000_0000);

        // full forward turn with throttle steps
        send_request(mk_pass(3'd4, 32'd1000, 1'b1, 8'h00), 0);
        send_request(mk_pass(3'd6, 32'd2000, 1'b1, 8'h01), 0);
        send_request(mk_pass(3'd2, 32'd3000, 1'b1, 8'h20), 0);
        send_request(mk_pass(3'd3, 32'd4000, 1'b1, 8'h3F), 0);
        send_request(mk_pass(3'd1, 32'd5000, 1'b0, 8'h00), 0);
        send_request(mk_pass(3'd5, 32'd6000, 1'b0, 8'h00), 0);
        // time standing still, zero period
        send_request(mk_pass(3'd5, 32'd6000, 1'b0, 8'h00), 0);
        send_request(mk_pass(3'd4, 32'd6000, 1'b0, 8'h00), 0);
        // timer wrap and periods over the timeout
        send_request(mk_pass(3'd6, 32'hFFFF_FF00, 1'b0, 8'h00), 0);
        send_request(mk_pass(3'd2, 32'h0000_0100, 1'b0, 8'h00), 0);
        send_request(mk_pass(3'd3, 32'h0001_0200, 1'b0, 8'h00), 0);
        // invalid codes accepted as the stable hall
        send_request(mk_pass(3'd0, 32'h0001_0300, 1'b0, 8'h00), 0);
        send_request(mk_pass(3'd7, 32'h0001_0400, 1'b0, 8'h00), 0);
        send_request(mk_pass(3'd1, 32'h0001_0400, 1'b1, 8'h00), 0);

        // random passes over several register settings
        run_phase(1'b0, 1023, 20, 16000, 10, 32'd100000, 180);
        run_phase(1'b1, 65535, 0, 65535, 1, 32'd1, 160);
        run_phase(1'b0, 1, 255, 0, 3, 32'hFFFF_FFFF, 140);
        run_phase(1'b1, 4000, 40, 20000, 255, 32'd0, 260);
        run_phase(1'b0, 2047, 60, 16000, 0, 32'd50000, 280);
        for (p = 0; p < 4; p++)
            run_phase($urandom_range(0, 1), $urandom_range(1, 65535), $urandom_range(0, 255),
                      $urandom_range(200, 30000), $urandom_range(1, 12),
                      $urandom_range(1, 300000), 110);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
